@@ rtl/skvt_pkg.sv @@
// ----------------------------------------------------------------------------
// skvt_pkg: shared types for the sorted key/value table
// Beat layouts of both channels, result status codes and the command and
// status groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package skvt_pkg;

    // Width of each half of a name key and of the stored number
    localparam int KEY_W = 56;
    localparam int VAL_W = 32;

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_LIST   = 1'b1
    } opcode_t;

    typedef enum logic [1:0]
    {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_ENTRY    = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    // One request beat
    typedef struct packed
    {
        opcode_t                  opcode;
        logic [KEY_W-1:0]         key_high;
        logic [KEY_W-1:0]         key_low;
        logic signed [VAL_W-1:0]  phone_value;
    } req_t;

    // One result beat
    typedef struct packed
    {
        status_t                  status;
        logic [KEY_W-1:0]         out_key_high;
        logic [KEY_W-1:0]         out_key_low;
        logic signed [VAL_W-1:0]  out_value;
        logic                     is_last;
    } rsp_t;

    // One table entry as held in the memory
    typedef struct packed
    {
        logic [KEY_W-1:0]         key_high;
        logic [KEY_W-1:0]         key_low;
        logic [VAL_W-1:0]         value;
    } entry_t;

    // Commands from the controller to the datapath
    typedef struct packed
    {
        logic    latch;        // capture the accepted request
        logic    idx_top;      // index to the last stored entry
        logic    idx_zero;     // index to the first entry
        logic    idx_dec;
        logic    idx_inc;
        logic    rd_en;        // read the entry at the index
        logic    wr_shift;     // move the read entry up by one place
        logic    wr_new;       // write the new entry
        logic    new_at_zero;  // new entry goes to place zero, else index plus one
        logic    cnt_inc;
        logic    out_load;     // load the result register
        logic    out_entry;    // result carries the read entry
        status_t out_status;
        logic    out_last;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed
    {
        logic is_list;
        logic empty;
        logic full;
        logic ram_greater;     // read entry key is above the new key
        logic idx_zero;
        logic idx_last;        // index is at the last stored entry
        logic out_free;        // result register can take a beat this cycle
    } sts_t;

endpackage

`default_nettype wire

@@ rtl/skvt_ram.sv @@
// ----------------------------------------------------------------------------
// skvt_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered and holds
// while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module skvt_ram #(
    parameter int WIDTH = 144,
    parameter int DEPTH = 64
) (
    input  wire                      clk,
    input  wire                      wr_en,
    input  wire  [$clog2(DEPTH)-1:0] wr_addr,
    input  wire  [WIDTH-1:0]         wr_data,
    input  wire                      rd_en,
    input  wire  [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Storage array and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/skvt_ctrl.sv @@
// ----------------------------------------------------------------------------
// skvt_ctrl: sequencing controller of the sorted key/value table
// Decodes each request and steps the datapath through the scan-and-shift
// of an insert or the walk over the entries of a list.
// ----------------------------------------------------------------------------
`default_nettype none

module skvt_ctrl
    import skvt_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        req_valid,
    output logic       req_stall,
    output cmd_t       cmd,
    input  wire sts_t  sts
);

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_DECODE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_PLACE,
        S_REPLY,
        S_LIST_RD,
        S_LIST_OUT
    } state_t;

    state_t  state_reg, state_next;
    status_t reply_reg, reply_next;
    logic    at_zero_reg, at_zero_next;

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        reply_next   = reply_reg;
        at_zero_next = at_zero_reg;
        cmd          = '0;
        cmd.out_status  = reply_reg;
        cmd.new_at_zero = at_zero_reg;
        req_stall    = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                if (sts.is_list)
                begin
                    if (sts.empty)
                    begin
                        reply_next = ST_EMPTY;
                        state_next = S_REPLY;
                    end
                    else
                    begin
                        cmd.idx_zero = 1'b1;
                        state_next   = S_LIST_RD;
                    end
                end
                else if (sts.full)
                begin
                    reply_next = ST_FULL;
                    state_next = S_REPLY;
                end
                else if (sts.empty)
                begin
                    at_zero_next = 1'b1;
                    state_next   = S_PLACE;
                end
                else
                begin
                    cmd.idx_top = 1'b1;
                    state_next  = S_SCAN_RD;
                end
            end

            S_SCAN_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_SCAN_CMP;
            end

            // Entries above the new key move up; the first one not above stops the scan
            S_SCAN_CMP:
            begin
                if (sts.ram_greater)
                begin
                    cmd.wr_shift = 1'b1;
                    if (sts.idx_zero)
                    begin
                        at_zero_next = 1'b1;
                        state_next   = S_PLACE;
                    end
                    else
                    begin
                        cmd.idx_dec = 1'b1;
                        state_next  = S_SCAN_RD;
                    end
                end
                else
                begin
                    at_zero_next = 1'b0;
                    state_next   = S_PLACE;
                end
            end

            S_PLACE:
            begin
                cmd.wr_new  = 1'b1;
                cmd.cnt_inc = 1'b1;
                reply_next  = ST_INSERTED;
                state_next  = S_REPLY;
            end

            S_REPLY:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            S_LIST_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_LIST_OUT;
            end

            S_LIST_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_entry  = 1'b1;
                    cmd.out_status = ST_ENTRY;
                    cmd.out_last   = sts.idx_last;
                    if (sts.idx_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_LIST_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, reply status and placement flag registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            reply_reg   <= ST_INSERTED;
            at_zero_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            reply_reg   <= reply_next;
            at_zero_reg <= at_zero_next;
        end
    end

    // A shift or a placement never coincides with taking a new request
    a_no_latch_while_writing: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.latch |-> !(cmd.wr_shift || cmd.wr_new))
        else $error("request taken while the table is being written");

    // A list beat only leaves from S_LIST_OUT, after its entry was read in S_LIST_RD
    a_list_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && cmd.out_entry) |-> $past(state_reg) == S_LIST_RD
                                           || $past(state_reg) == S_LIST_OUT)
        else $error("list beat issued without a preceding read");

endmodule

`default_nettype wire

@@ rtl/skvt_dpath.sv @@
// ----------------------------------------------------------------------------
// skvt_dpath: datapath of the sorted key/value table
// Holds the request, the entry count, the scan index, the entry memory and
// the result register with its handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module skvt_dpath
    import skvt_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int NAME_BYTES = 14
) (
    input  wire        clk,
    input  wire        rst_n,
    input  wire req_t  req,
    input  wire cmd_t  cmd,
    output sts_t       sts,
    output logic       rsp_valid,
    input  wire        rsp_stall,
    output rsp_t       rsp
);

    localparam int AW       = $clog2(DEPTH);
    localparam int CW       = $clog2(DEPTH + 1);
    localparam int KEY2_W   = 2 * KEY_W;
    localparam int NAME_MAX = KEY2_W / 8;
    localparam int ENTRY_W  = $bits(entry_t);

    // Clears every byte from the first zero byte on and beyond the name length
    function automatic logic [KEY2_W-1:0] tidy_key(input logic [KEY2_W-1:0] raw);
        logic [KEY2_W-1:0] kept;
        logic [7:0]        name_byte;
        logic              ended;
        kept  = '0;
        ended = 1'b0;
        for (int b = 0; b < NAME_MAX; b++)
        begin
            name_byte = raw[(NAME_MAX - 1 - b) * 8 +: 8];
            if (b >= NAME_BYTES || name_byte == 8'd0)
            begin
                ended = 1'b1;
            end
            if (!ended)
            begin
                kept[(NAME_MAX - 1 - b) * 8 +: 8] = name_byte;
            end
        end
        return kept;
    endfunction

    opcode_t           op_reg;
    logic [KEY2_W-1:0] key_reg;
    logic [VAL_W-1:0]  val_reg;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [AW-1:0]     idx_up;
    logic              out_valid_reg, out_valid_next;
    rsp_t              out_reg, out_next;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    entry_t            wr_entry;
    entry_t            rd_entry;
    logic [ENTRY_W-1:0] rd_word;

    assign idx_up   = idx_reg + AW'(1);
    assign rd_entry = entry_t'(rd_word);

    // Request capture; the key is tidied on the way in
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg  <= req.opcode;
            key_reg <= tidy_key({req.key_high, req.key_low});
            val_reg <= req.phone_value;
        end
    end

    // Entry count and scan index
    always_comb
    begin
        count_next = count_reg;
        idx_next   = idx_reg;
        if (cmd.cnt_inc)
        begin
            count_next = count_reg + CW'(1);
        end
        if (cmd.idx_top)
        begin
            idx_next = count_reg[AW-1:0] - AW'(1);
        end
        else if (cmd.idx_zero)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_dec)
        begin
            idx_next = idx_reg - AW'(1);
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_up;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    // Memory write port: an entry moving up, or the new entry
    always_comb
    begin
        wr_en    = cmd.wr_shift || cmd.wr_new;
        wr_addr  = idx_up;
        wr_entry = rd_entry;
        if (cmd.wr_new)
        begin
            wr_entry.key_high = key_reg[KEY2_W-1:KEY_W];
            wr_entry.key_low  = key_reg[KEY_W-1:0];
            wr_entry.value    = val_reg;
            if (cmd.new_at_zero)
            begin
                wr_addr = '0;
            end
        end
    end

    skvt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (cmd.rd_en),
        .rd_addr (idx_reg),
        .rd_data (rd_word)
    );

    // Status towards the controller
    always_comb
    begin
        sts.is_list     = (op_reg == OP_LIST);
        sts.empty       = (count_reg == '0);
        sts.full        = (count_reg == CW'(DEPTH));
        sts.ram_greater = {rd_entry.key_high, rd_entry.key_low} > key_reg;
        sts.idx_zero    = (idx_reg == '0);
        sts.idx_last    = ((CW'(idx_reg) + CW'(1)) == count_reg);
        sts.out_free    = !out_valid_reg || !rsp_stall;
    end

    // Result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            out_next       = '0;
            out_next.status  = cmd.out_status;
            out_next.is_last = cmd.out_last;
            if (cmd.out_entry)
            begin
                out_next.out_key_high = rd_entry.key_high;
                out_next.out_key_low  = rd_entry.key_low;
                out_next.out_value    = rd_entry.value;
            end
        end
        else if (!rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // A result beat is never loaded over one that is still stalled
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || !rsp_stall))
        else $error("result register overwritten while stalled");

    // The table grows by at most one entry at a time and never past its depth
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |-> count_reg == $past(count_reg) + CW'(1)
                                          && count_reg <= CW'(DEPTH))
        else $error("entry count moved by more than one");

    // An entry only moves up while it sorts above the new key
    a_shift_greater: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_shift |-> sts.ram_greater && !cmd.wr_new)
        else $error("entry shifted that does not sort above the new key");

endmodule

`default_nettype wire

@@ rtl/sorted_key_value_table.sv @@
// ----------------------------------------------------------------------------
// sorted_key_value_table: name/number table kept in ascending key order
// Inserts entries in place (equal keys after existing ones) and lists the
// whole table in order on request.
//
//   channel   direction   beat    handshake
//   req       in          req_t   req_valid / req_stall
//   rsp       out         rsp_t   rsp_valid / rsp_stall
//
// An insert reads the stored entries from the top down and moves each one
// up while it sorts above the new key, then writes the new entry in place;
// a list reads and sends each stored entry in turn. An empty list or a
// dropped insert gives one status beat. The single read port of the entry
// memory, with its registered read, paces them; a result stall adds its wait.
// Reset clears the entry count, the result valid and the controller; the
// memory needs no clearing.
// A stalled result beat holds; the next request is still taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_value_table
    import skvt_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int NAME_BYTES = 14
) (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        req_valid,
    output logic       req_stall,
    input  wire req_t  req,
    output logic       rsp_valid,
    input  wire        rsp_stall,
    output rsp_t       rsp
);

    cmd_t cmd;
    sts_t sts;

    // Sequencing controller
    skvt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Table storage and result register
    skvt_dpath #(
        .DEPTH      (DEPTH),
        .NAME_BYTES (NAME_BYTES)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the sorted key/value table
// Drives insert and list beats with random pacing on both channels, keeps
// its own ordered copy of the table to predict every result beat, and
// compares each accepted result beat field by field in arrival order.
// ----------------------------------------------------------------------------

import skvt_pkg::*;

module tb_top;

    localparam int TABLE_DEPTH  = 64;
    localparam int NAME_LEN     = 14;
    localparam int RANDOM_ITEMS = 455;
    localparam int CALM_FROM    = 395;
    localparam int CYCLE_LIMIT  = 1500000;

    // Ordered table copy: predicts the result beats of each accepted request
    class table_ledger;
        entry_t rows [TABLE_DEPTH];
        int     fill    = 0;
        rsp_t   awaited [$];
        int     errors  = 0;
        int     inserts = 0;
        int     drops   = 0;
        int     lists   = 0;
        int     beats   = 0;

        // A name ends at its first zero byte; everything after it reads as zero.
        function logic [111:0] tidy(logic [111:0] raw);
            logic [111:0] kept;
            bit           ended;
            int           b;
            kept  = '0;
            ended = 1'b0;
            for (b = 0; b < 14; b++)
            begin
                if (b >= NAME_LEN || raw[111 - 8 * b -: 8] == 8'h00)
                    ended = 1'b1;
                if (!ended)
                    kept[111 - 8 * b -: 8] = raw[111 - 8 * b -: 8];
            end
            return kept;
        endfunction

        function rsp_t beat(status_t code, entry_t e, logic last);
            rsp_t b;
            b.status       = code;
            b.out_key_high = e.key_high;
            b.out_key_low  = e.key_low;
            b.out_value    = e.value;
            b.is_last      = last;
            return b;
        endfunction

        // Update the table copy for an accepted request and queue its results.
        function void note_request(req_t item);
            logic [111:0] name;
            entry_t       blank;
            int           slot;
            int           i;
            blank = '0;
            if (item.opcode == OP_LIST)
            begin
                lists++;
                if (fill == 0)
                    awaited.push_back(beat(ST_EMPTY, blank, 1'b1));
                for (i = 0; i < fill; i++)
                    awaited.push_back(beat(ST_ENTRY, rows[i], i == fill - 1));
            end
            else if (fill == TABLE_DEPTH)
            begin
                drops++;
                awaited.push_back(beat(ST_FULL, blank, 1'b1));
            end
            else
            begin
                inserts++;
                name = tidy({item.key_high, item.key_low});
                // First stored key strictly above the new one; equal keys stay ahead.
                slot = fill;
                for (i = 0; i < fill; i++)
                    if (slot == fill && {rows[i].key_high, rows[i].key_low} > name)
                        slot = i;
                for (i = fill; i > slot; i--)
                    rows[i] = rows[i - 1];
                rows[slot].key_high = name[111:56];
                rows[slot].key_low  = name[55:0];
                rows[slot].value    = item.phone_value;
                fill++;
                awaited.push_back(beat(ST_INSERTED, blank, 1'b1));
            end
        endfunction

        task report(string what);
            errors++;
            $display("MISMATCH at %0t: %s", $time, what);
        endtask

        // Compare one accepted result beat with the oldest prediction.
        task check_result(rsp_t got);
            rsp_t want;
            if (awaited.size() == 0)
            begin
                report($sformatf("result beat with nothing pending, status %0d",
                                 got.status));
                return;
            end
            want = awaited.pop_front();
            beats++;
            if (got.status !== want.status)
                report($sformatf("status %0d, wanted %0d", got.status, want.status));
            if (got.out_key_high !== want.out_key_high)
                report($sformatf("out_key_high %h, wanted %h",
                                 got.out_key_high, want.out_key_high));
            if (got.out_key_low !== want.out_key_low)
                report($sformatf("out_key_low %h, wanted %h",
                                 got.out_key_low, want.out_key_low));
            if (got.out_value !== want.out_value)
                report($sformatf("out_value %h, wanted %h",
                                 got.out_value, want.out_value));
            if (got.is_last !== want.is_last)
                report($sformatf("is_last %b, wanted %b", got.is_last, want.is_last));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    table_ledger ledger = new();

    logic [111:0] name_pool [8];
    int           pool_len  [8];
    int           gap_odds   = 0;
    int           stall_odds = 0;
    bit           calm       = 1'b0;
    int           cycles     = 0;

    sorted_key_value_table #(
        .DEPTH      (TABLE_DEPTH),
        .NAME_BYTES (NAME_LEN)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Name of len nonzero bytes, zero padded; narrow names use few byte values
    // so that near ties and equal keys turn up often.
    function automatic logic [111:0] build_name(int len, bit narrow);
        logic [111:0] name;
        int           b;
        name = '0;
        for (b = 0; b < len; b++)
        begin
            if (!narrow)
                name[111 - 8 * b -: 8] = 8'($urandom_range(1, 255));
            else
                case ($urandom_range(0, 3))
                    0:       name[111 - 8 * b -: 8] = 8'h01;
                    1:       name[111 - 8 * b -: 8] = 8'h41;
                    2:       name[111 - 8 * b -: 8] = 8'h42;
                    default: name[111 - 8 * b -: 8] = 8'hFF;
                endcase
        end
        return name;
    endfunction

    // Fill the bytes beyond the terminating zero with rubbish.
    function automatic logic [111:0] add_tail(logic [111:0] name, int len);
        int b;
        for (b = len + 1; b < 14; b++)
            name[111 - 8 * b -: 8] = 8'($urandom_range(0, 255));
        return name;
    endfunction

    function automatic logic [111:0] random_name();
        logic [111:0] name;
        int           len;
        int           idx;
        int           b;
        case ($urandom_range(0, 9))
            0, 1, 2:
            begin
                idx  = $urandom_range(0, 7);
                name = name_pool[idx];
                if ($urandom_range(0, 1) == 1)
                    name = add_tail(name, pool_len[idx]);
            end
            3, 4, 5:
            begin
                len  = $urandom_range(0, 14);
                name = build_name(len, 1'b0);
                if ($urandom_range(0, 1) == 1)
                    name = add_tail(name, len);
            end
            6, 7:
            begin
                name = '0;
                for (b = 0; b < 14; b++)
                    name[111 - 8 * b -: 8] = 8'($urandom_range(0, 255));
            end
            default:
                name = build_name($urandom_range(1, 14), 1'b1);
        endcase
        return name;
    endfunction

    function automatic req_t random_item();
        req_t item;
        item.opcode                   = ($urandom_range(0, 2) == 0) ? OP_LIST : OP_INSERT;
        {item.key_high, item.key_low} = random_name();
        item.phone_value              = $urandom;
        return item;
    endfunction

    function automatic logic [111:0] text_name(string s);
        logic [111:0] name;
        int           i;
        name = '0;
        for (i = 0; i < s.len() && i < 14; i++)
            name[111 - 8 * i -: 8] = s[i];
        return name;
    endfunction

    // Present one request beat after an optional gap and hold it until taken.
    task automatic send_item(input req_t item, input int gap);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            req       <= random_item();
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        ledger.note_request(item);
    endtask

    task automatic send_insert(input logic [111:0] name, input logic [31:0] value);
        req_t item;
        item.opcode                   = OP_INSERT;
        {item.key_high, item.key_low} = name;
        item.phone_value              = value;
        send_item(item, 0);
    endtask

    task automatic send_list();
        req_t item;
        item             = random_item();
        item.opcode      = OP_LIST;
        send_item(item, 0);
    endtask

    // Hold the request side back until every predicted beat has arrived.
    task automatic wait_drained();
        req_valid <= 1'b0;
        while (ledger.awaited.size() != 0)
            @(posedge clk);
    endtask

    // Result checking on every accepted result beat
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            ledger.check_result(rsp);
    end

    // Result side back-pressure in random bursts
    initial
    begin : rsp_pacing
        int hold;
        rsp_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!calm && stall_odds != 0 && $urandom_range(0, stall_odds) == 0)
            begin
                hold = $urandom_range(1, 9);
                rsp_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    // Watchdog
    initial
    begin : watchdog
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("[sorted_key_value_table] ERROR");
        $finish;
    end

    // Stimulus
    initial
    begin : stimulus
        req_t item;
        int   n;
        int   gap;
        int   i;

        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        for (i = 0; i < 8; i++)
        begin
            pool_len[i]  = $urandom_range(0, 14);
            name_pool[i] = build_name(pool_len[i], i[0]);
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty list, extreme names and values, ties and prefixes
        send_list();
        send_insert({14{8'hFF}}, 32'h7FFF_FFFF);
        send_insert('0, 32'h8000_0000);
        send_insert({8'h00, {13{8'hA5}}}, 32'd5);
        send_insert(text_name("B"), 32'hFFFF_FFFF);
        send_insert({8'h42, 8'h00, {12{8'h5A}}}, 32'd1);
        send_insert(text_name("A"), 32'd2);
        send_insert(text_name("AAAAAAAAAAAAAA"), 32'd3);
        send_insert(text_name("AAAAAAAAAAAAA@"), 32'd4);
        send_insert(text_name("AAAAAAA"), 32'd6);
        send_insert(text_name("AAAAAAAB"), 32'd7);
        send_list();
        send_insert({14{8'hFF}}, 32'd0);
        send_insert({{7{8'h55}}, {7{8'hAA}}}, 32'h5555_AAAA);
        send_list();
        wait_drained();
        send_list();

        // Random traffic with changing pace; quiet pacing towards the end
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 40 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       gap_odds = 0;
                    1:       gap_odds = 2;
                    default: gap_odds = 6;
                endcase
                case ($urandom_range(0, 2))
                    0:       stall_odds = 0;
                    1:       stall_odds = 2;
                    default: stall_odds = 6;
                endcase
            end
            if (n == CALM_FROM)
                calm = 1'b1;
            if (n == 200)
                wait_drained();
            gap = 0;
            if (!calm && gap_odds != 0 && $urandom_range(0, gap_odds) == 0)
                gap = $urandom_range(1, 9);
            item = random_item();
            send_item(item, gap);
        end

        wait_drained();
        repeat (32) @(posedge clk);
        @(negedge clk);

        $display("covered %0d inserts, %0d dropped on a full table, %0d lists; %0d result beats",
                 ledger.inserts, ledger.drops, ledger.lists, ledger.beats);
        $display("table holds %0d of %0d entries after %0d cycles, %0d mismatches",
                 ledger.fill, TABLE_DEPTH, cycles, ledger.errors);
        if (ledger.errors == 0)
            $display("[sorted_key_value_table] OK");
        else
            $display("[sorted_key_value_table] ERROR");
        $finish;
    end

endmodule
